### src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("property violated");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("property violated");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### src/nhrm_pkg.sv
// Package: constants and payload types for the nearest-hit block.
`default_nettype none
package nhrm_pkg;
  localparam int MAX_HITS_DEF = 16;
  localparam int OBJECT_COUNT_DEF = 256;

  typedef struct packed {
    logic signed [31:0] distance;
    logic [7:0] object_id;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic [30:0] near_distance;
    logic [7:0] near_object;
    logic [7:0] medium_before;
    logic [7:0] medium_after;
    logic overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_AHEAD,
    ST_REPORT
  } state_t;
endpackage
`default_nettype wire

### src/nhrm_cell.sv
// Store cell: one slot of the sorted negative-hit chain.
`default_nettype none
module nhrm_cell (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic clear,
  input  wire logic ins,
  input  wire logic shift,
  input  wire logic signed [31:0] new_dist,
  input  wire logic [7:0] new_obj,
  input  wire logic prev_valid,
  input  wire logic prev_gt,
  input  wire logic signed [31:0] prev_dist,
  input  wire logic [7:0] prev_obj,
  input  wire logic next_valid,
  input  wire logic [7:0] next_obj,
  output logic valid,
  output logic gt,
  output logic signed [31:0] slot_dist,
  output logic [7:0] obj
);
  // gt: this slot holds a larger distance than the new one, so it moves up
  assign gt = valid && (slot_dist > new_dist);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (ins) begin
      // fill the first empty slot; occupied slots stay occupied
      valid <= valid || prev_valid;
    end else if (shift) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      if (prev_gt) begin
        slot_dist <= prev_dist;
        obj       <= prev_obj;
      end else if (gt || (!valid && prev_valid)) begin
        slot_dist <= new_dist;
        obj       <= new_obj;
      end
    end else if (shift) begin
      obj <= next_obj;
    end
  end
endmodule
`default_nettype wire

### src/nhrm_ctr.sv
// Container cell: one entry of the ordered container list.
`default_nettype none
module nhrm_ctr (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic clear,
  input  wire logic tog,
  input  wire logic [7:0] tog_obj,
  input  wire logic prev_hit,
  input  wire logic prev_valid,
  input  wire logic next_valid,
  input  wire logic [7:0] next_obj,
  output logic valid,
  output logic match_out,
  output logic [7:0] obj
);
  logic match_here;
  assign match_here = valid && (obj == tog_obj);
  // match_out: a match was found in this or an earlier entry
  assign match_out = prev_hit || match_here;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (tog) begin
      if (prev_valid && !valid) begin
        if (!prev_hit) valid <= 1'b1;
      end else if (match_out && valid) begin
        valid <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tog) begin
      if (prev_valid && !valid && !prev_hit) obj <= tog_obj;
      else if (match_out && valid) obj <= next_obj;
    end
  end
endmodule
`default_nettype wire

### src/nearest_hit_refraction_media.sv
// Nearest-hit selection with refraction container tracking (top level).
// A last item starts the walk, which shifts the stored negative hits into the
// containers one store cell per cycle; the ahead and report states follow.
// Throughput: one item per cycle while loading; busy is high in the walk, ahead and report states.
// Reset (rst, synchronous) clears the store, containers and default_object.
// Results are held for one cycle under done; the receiver cannot stall.
`default_nettype none
module nearest_hit_refraction_media #(
  parameter int MAX_HITS = nhrm_pkg::MAX_HITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire nhrm_pkg::in_item_t in_item,
  output logic done,
  output nhrm_pkg::out_item_t out_item,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [7:0] cfg_data
);
  import nhrm_pkg::*;
  `include "assert_macros.svh"

  localparam int OBJECT_COUNT = OBJECT_COUNT_DEF;
  localparam int CW = MAX_HITS + 1;
  localparam int OBJ_MASK = OBJECT_COUNT - 1;

  state_t state, state_next;
  logic [7:0] default_object;
  logic accept, ins, walk_shift, tog, clear;
  logic signed [31:0] best_dist;
  logic [7:0] best_obj, tog_obj, med_before, innermost, obj_in;
  logic ahead_seen, dropped, ahead_tog;
  logic [MAX_HITS-1:0] s_valid, s_gt;
  logic signed [31:0] s_dist [MAX_HITS];
  logic [7:0] s_obj [MAX_HITS];
  logic [CW-1:0] c_valid, c_match;
  logic [7:0] c_obj [CW];

  assign obj_in = (OBJECT_COUNT >= 256) ? in_item.object_id
                                         : (in_item.object_id & 8'(OBJ_MASK));
  assign cfg_ready = !busy;
  assign accept = start && !busy;
  assign ins = accept && in_item.distance < 0 && !s_valid[MAX_HITS-1];
  assign walk_shift = (state == ST_WALK) && s_valid[0];
  assign ahead_tog = (state == ST_AHEAD) && ahead_seen;
  assign tog = walk_shift || ahead_tog;
  assign tog_obj = walk_shift ? s_obj[0] : best_obj;
  assign clear = (state == ST_REPORT);

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   if (accept && in_item.last) state_next = ST_WALK;
      ST_WALK:   if (!s_valid[0] || !ahead_seen) state_next = ST_AHEAD;
      ST_AHEAD:  state_next = ST_REPORT;
      ST_REPORT: state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    busy = (state != ST_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) default_object <= 8'd0;
    else if (cfg_valid && cfg_ready)
      default_object <= (OBJECT_COUNT >= 256) ? cfg_data : (cfg_data & 8'(OBJ_MASK));
  end

  // Track the nearest ahead hit and the drop flag while loading
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ahead_seen <= 1'b0;
      dropped <= 1'b0;
      best_dist <= '0;
      best_obj <= '0;
    end else if (accept) begin
      if (in_item.distance >= 0) begin
        if (!ahead_seen || in_item.distance < best_dist) begin
          best_dist <= in_item.distance;
          best_obj <= obj_in;
          ahead_seen <= 1'b1;
        end
      end else if (s_valid[MAX_HITS-1]) begin
        dropped <= 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_HITS; g++) begin : g_store
      nhrm_cell u_cell (
        .clk(clk), .rst(rst), .clear(clear), .ins(ins), .shift(walk_shift),
        .new_dist(in_item.distance), .new_obj(obj_in),
        .prev_valid((g == 0) ? 1'b1 : s_valid[(g == 0) ? 0 : g-1]),
        .prev_gt((g == 0) ? 1'b0 : s_gt[(g == 0) ? 0 : g-1]),
        .prev_dist(s_dist[(g == 0) ? 0 : g-1]),
        .prev_obj(s_obj[(g == 0) ? 0 : g-1]),
        .next_valid((g == MAX_HITS-1) ? 1'b0 : s_valid[(g == MAX_HITS-1) ? g : g+1]),
        .next_obj(s_obj[(g == MAX_HITS-1) ? g : g+1]),
        .valid(s_valid[g]), .gt(s_gt[g]), .slot_dist(s_dist[g]), .obj(s_obj[g])
      );
    end
    for (g = 0; g < CW; g++) begin : g_ctr
      nhrm_ctr u_ctr (
        .clk(clk), .rst(rst), .clear(clear), .tog(tog), .tog_obj(tog_obj),
        .prev_hit((g == 0) ? 1'b0 : c_match[(g == 0) ? 0 : g-1]),
        .prev_valid((g == 0) ? 1'b1 : c_valid[(g == 0) ? 0 : g-1]),
        .next_valid((g == CW-1) ? 1'b0 : c_valid[(g == CW-1) ? g : g+1]),
        .next_obj(c_obj[(g == CW-1) ? g : g+1]),
        .valid(c_valid[g]), .match_out(c_match[g]), .obj(c_obj[g])
      );
    end
  endgenerate

  // Innermost medium: newest open container, or the default when none is open
  always_comb begin
    innermost = default_object;
    for (int i = 0; i < CW; i++) begin
      if (c_valid[i]) innermost = c_obj[i];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_AHEAD) med_before <= innermost;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= clear;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      out_item.hit <= ahead_seen;
      out_item.near_distance <= ahead_seen ? best_dist[30:0] : 31'd0;
      out_item.near_object <= ahead_seen ? best_obj : 8'd0;
      out_item.medium_before <= ahead_seen ? med_before : 8'd0;
      out_item.medium_after <= ahead_seen ? innermost : 8'd0;
      out_item.overflow <= dropped;
    end
  end

  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, state == ST_LOAD)
  `ASSERT_NEXT(a_clear_empty, clk, rst, clear, !s_valid[0] && !c_valid[0])
  `ASSERT_IMPLIES(a_no_ins_busy, clk, rst, busy, !ins)
endmodule
`default_nettype wire
